[src/conv3x3_rgb_center_border_defines.svh]
// Assertion macros shared by the filter RTL.
`ifndef CONV3X3_RGB_CENTER_BORDER_DEFINES_SVH
`define CONV3X3_RGB_CENTER_BORDER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define C3_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("c3rgb assertion failed");
// Next-cycle implication, disabled during reset.
`define C3_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("c3rgb assertion failed");
`else
`define C3_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define C3_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

[src/c3rgb_pkg.sv]
// Shared constants and helpers of the 3x3 RGB filter.
package c3rgb_pkg;
    localparam int MAX_WIDTH  = 2048;
    localparam int RING_SLOTS = 2 * MAX_WIDTH + 3;
    localparam int SLOT_W     = $clog2(RING_SLOTS);
    localparam int WID_W      = $clog2(MAX_WIDTH + 3);
    localparam int IW_W       = 12;
    localparam int KERN_W     = 24;
    localparam int NORM_W     = 16;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int SUM_W      = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALISER    = 3'd4;

    // Signed weight for one column of a kernel row register.
    function automatic logic signed [7:0] kernel_weight(input logic [KERN_W-1:0] row,
                                                       input logic [1:0] col);
        logic signed [7:0] k;
        case (col)
            2'd0:    k = $signed(row[7:0]);
            2'd1:    k = $signed(row[15:8]);
            2'd2:    k = $signed(row[23:16]);
            default: k = $signed(row[7:0]);
        endcase
        return k;
    endfunction
endpackage

[src/c3rgb_if.sv]
// Request channel interfaces for pixels in and filtered pixels out.
interface c3rgb_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, mode, red_in, green_in, blue_in, input ready);
    modport sink (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface c3rgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
    modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
    modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

[src/c3rgb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module c3rgb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4099
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[src/c3rgb_div.sv]
// Three-lane restoring divider with clamp of the quotient to 0..255.
module c3rgb_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [c3rgb_pkg::SUM_W-1:0]  sum_r,
    input  logic signed [c3rgb_pkg::SUM_W-1:0]  sum_g,
    input  logic signed [c3rgb_pkg::SUM_W-1:0]  sum_b,
    input  logic [c3rgb_pkg::NORM_W-1:0]        normaliser,
    output logic                                done,
    output logic [c3rgb_pkg::CH_W-1:0]          quot_r,
    output logic [c3rgb_pkg::CH_W-1:0]          quot_g,
    output logic [c3rgb_pkg::CH_W-1:0]          quot_b
);
    import c3rgb_pkg::*;

    localparam int REM_W = NORM_W + CH_W;

    logic                   busy_reg;
    logic                   done_reg;
    logic [2:0]             bit_reg;
    logic [NORM_W-1:0]      div_reg;
    logic [REM_W-1:0]       rem_reg [3];
    logic [CH_W-1:0]        q_reg [3];
    logic                   sat_reg [3];
    logic signed [SUM_W-1:0] sum_in [3];
    logic [REM_W-1:0]       dshift;
    logic [REM_W-1:0]       dfull;
    logic [NORM_W-1:0]      dstart;

    assign sum_in[0] = sum_r;
    assign sum_in[1] = sum_g;
    assign sum_in[2] = sum_b;

    // A zero divisor acts as one.
    assign dstart = (normaliser == '0) ? NORM_W'(1) : normaliser;
    assign dfull  = {dstart, {CH_W{1'b0}}};
    assign dshift = REM_W'(div_reg) << bit_reg;

    // Control: eight quotient bits, one per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= 3'd7;
            end
            else if (busy_reg)
            begin
                bit_reg <= bit_reg - 3'd1;
                if (bit_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: a non-positive sum gives zero, a sum at or over 256 times the divisor saturates.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= dstart;
            for (int i = 0; i < 3; i++)
            begin
                q_reg[i] <= '0;
                if (sum_in[i] <= 0)
                begin
                    rem_reg[i] <= '0;
                    sat_reg[i] <= 1'b0;
                end
                else
                begin
                    rem_reg[i] <= REM_W'(sum_in[i]);
                    sat_reg[i] <= (REM_W'(sum_in[i]) >= dfull);
                end
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_reg[i] >= dshift)
                begin
                    rem_reg[i]          <= rem_reg[i] - dshift;
                    q_reg[i][bit_reg]   <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign quot_r = sat_reg[0] ? {CH_W{1'b1}} : q_reg[0];
    assign quot_g = sat_reg[1] ? {CH_W{1'b1}} : q_reg[1];
    assign quot_b = sat_reg[2] ? {CH_W{1'b1}} : q_reg[2];
endmodule

[src/conv3x3_rgb_center_border.sv]
// Top level of the 3x3 RGB convolution filter with centre-replicated borders.
//
//   channel   direction  handshake         payload
//   in_ch     in         valid/ready       mode, red_in, green_in, blue_in
//   out_ch    out        valid/ready       red_out, green_out, blue_out, frame_last
//   cfg       in         cfg_we            cfg_index, cfg_wdata
//
// A pixel that releases no output leaves the block idle. An item that releases an output
// passes through acceptance, location of the window, a gather pass that reads the nine
// neighbours through the single read port of the ring memory and sums them, the divider
// and the hand-over to the output register; no new item is taken until it is through.
// Reset clears the counters and the ring write pointer; the ring memory is not cleared.
// A result waiting in the output register stalls the block only when the next one is done.
module conv3x3_rgb_center_border (
    input  logic                                 clk,
    input  logic                                 rst_n,
    c3rgb_in_if.sink                             in_ch,
    c3rgb_out_if.source                          out_ch,
    input  logic                                 cfg_we,
    input  logic [c3rgb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [c3rgb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import c3rgb_pkg::*;
    `include "conv3x3_rgb_center_border_defines.svh"

    localparam int OFF_W = WID_W + 2;
    localparam int SL_W  = SLOT_W + 2;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_GATHER = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t                 state_reg;
    logic [IW_W-1:0]        image_width_reg;
    logic [KERN_W-1:0]      kern_top_reg;
    logic [KERN_W-1:0]      kern_mid_reg;
    logic [KERN_W-1:0]      kern_bot_reg;
    logic [NORM_W-1:0]      norm_reg;
    logic [SLOT_W-1:0]      head_reg;
    logic [WID_W-1:0]       col_reg;
    logic [15:0]            row_reg;
    logic [WID_W-1:0]       pend_reg;
    logic                   last_reg;
    logic [WID_W-1:0]       cc_reg;
    logic                   rr_zero_reg;
    logic [SLOT_W-1:0]      oslot_reg;
    logic [WID_W-1:0]       pend_use_reg;
    logic [3:0]             step_reg;
    logic                   inside_reg;
    logic [PIX_W-1:0]       center_reg;
    logic signed [SUM_W-1:0] sum_r_reg;
    logic signed [SUM_W-1:0] sum_g_reg;
    logic signed [SUM_W-1:0] sum_b_reg;
    logic                   out_valid_reg;
    logic [CH_W-1:0]        red_out_reg;
    logic [CH_W-1:0]        green_out_reg;
    logic [CH_W-1:0]        blue_out_reg;
    logic                   frame_last_reg;

    logic [WID_W-1:0]       w;
    logic [WID_W-1:0]       w_plus1;
    logic [WID_W-1:0]       pend_inc;
    logic [WID_W-1:0]       col_inc;
    logic                   accept;
    logic                   emit_pix;
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [PIX_W-1:0]       ram_rdata;
    logic [PIX_W-1:0]       pix_in;
    logic signed [OFF_W-1:0] cc_s;
    logic [15:0]            rr_s;
    logic [SLOT_W-1:0]      pend_sl;
    logic [SLOT_W-1:0]      oslot_next;
    logic [3:0]             cell_issue;
    logic [3:0]             cell_proc;
    logic [1:0]             dr_i;
    logic [1:0]             dc_i;
    logic [1:0]             dr_p;
    logic [1:0]             dc_p;
    logic signed [OFF_W-1:0] off;
    logic signed [SL_W-1:0] slot_s;
    logic                   inside_next;
    logic [PIX_W-1:0]       cell_pix;
    logic signed [7:0]      kw;
    logic [KERN_W-1:0]      kern_row;
    logic signed [16:0]     prod_r;
    logic signed [16:0]     prod_g;
    logic signed [16:0]     prod_b;
    logic                   div_start;
    logic                   div_done;
    logic [CH_W-1:0]        quot_r;
    logic [CH_W-1:0]        quot_g;
    logic [CH_W-1:0]        quot_b;
    logic                   out_load;

    // Effective width clamped to 1..MAX_WIDTH.
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w = WID_W'(1);
        end
        else if (32'(image_width_reg) > MAX_WIDTH)
        begin
            w = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w = WID_W'(image_width_reg);
        end
    end

    // Input acceptance and counter updates.
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign w_plus1     = w + WID_W'(1);
    assign pend_inc    = pend_reg + WID_W'(1);
    assign col_inc     = col_reg + WID_W'(1);
    assign emit_pix    = (pend_inc > w_plus1);
    assign ram_we      = accept && !in_ch.mode;
    assign pix_in      = {in_ch.blue_in, in_ch.green_in, in_ch.red_in};

    // Position of the output pixel and its ring slot.
    // With a width of one the output can lie three rows back.
    always_comb
    begin
        cc_s = $signed({2'b00, col_reg}) - $signed({2'b00, pend_reg});
        rr_s = row_reg;
        if (cc_s < 0)
        begin
            cc_s = cc_s + $signed({2'b00, w});
            rr_s = rr_s - 16'd1;
        end
        if (cc_s < 0)
        begin
            cc_s = cc_s + $signed({2'b00, w});
            rr_s = rr_s - 16'd1;
        end
        if (cc_s < 0)
        begin
            cc_s = cc_s + $signed({2'b00, w});
            rr_s = rr_s - 16'd1;
        end
    end

    assign pend_sl    = SLOT_W'(pend_reg);
    assign oslot_next = (head_reg >= pend_sl) ? (head_reg - pend_sl)
                      : (head_reg + SLOT_W'(RING_SLOTS) - pend_sl);

    // Window cell addressed at this step and the one whose data returns now.
    assign cell_issue = step_reg - 4'd1;
    assign cell_proc  = step_reg - 4'd2;

    always_comb
    begin
        case (cell_issue)
            4'd0, 4'd1, 4'd2: dr_i = 2'd0;
            4'd3, 4'd4, 4'd5: dr_i = 2'd1;
            default:          dr_i = 2'd2;
        endcase
        case (cell_issue)
            4'd0, 4'd3, 4'd6: dc_i = 2'd0;
            4'd1, 4'd4, 4'd7: dc_i = 2'd1;
            default:          dc_i = 2'd2;
        endcase
        case (cell_proc)
            4'd0, 4'd1, 4'd2: dr_p = 2'd0;
            4'd3, 4'd4, 4'd5: dr_p = 2'd1;
            default:          dr_p = 2'd2;
        endcase
        case (cell_proc)
            4'd0, 4'd3, 4'd6: dc_p = 2'd0;
            4'd1, 4'd4, 4'd7: dc_p = 2'd1;
            default:          dc_p = 2'd2;
        endcase
    end

    // Neighbour offset, inside test and wrapped ring slot.
    always_comb
    begin
        case (dr_i)
            2'd0:    off = -$signed({2'b00, w});
            2'd2:    off = $signed({2'b00, w});
            default: off = '0;
        endcase
        off = off + $signed({{(OFF_W-2){1'b0}}, dc_i}) - OFF_W'(1);

        inside_next = 1'b1;
        if (dc_i == 2'd0 && cc_reg == '0)
        begin
            inside_next = 1'b0;
        end
        if (dc_i == 2'd2 && (cc_reg + WID_W'(1)) >= w)
        begin
            inside_next = 1'b0;
        end
        if (dr_i == 2'd0 && rr_zero_reg)
        begin
            inside_next = 1'b0;
        end
        if (off > 0 && off >= $signed({2'b00, pend_use_reg}))
        begin
            inside_next = 1'b0;
        end

        slot_s = $signed({2'b00, oslot_reg}) + SL_W'(off);
        if (slot_s < 0)
        begin
            slot_s = slot_s + SL_W'(RING_SLOTS);
        end
        else if (slot_s >= SL_W'(RING_SLOTS))
        begin
            slot_s = slot_s - SL_W'(RING_SLOTS);
        end
    end

    assign ram_raddr = (step_reg == 4'd0) ? oslot_reg : slot_s[SLOT_W-1:0];

    // Weighted products of the returning cell.
    always_comb
    begin
        case (dr_p)
            2'd0:    kern_row = kern_top_reg;
            2'd1:    kern_row = kern_mid_reg;
            default: kern_row = kern_bot_reg;
        endcase
    end

    assign kw       = kernel_weight(kern_row, dc_p);
    assign cell_pix = inside_reg ? ram_rdata : center_reg;
    assign prod_r   = $signed({1'b0, cell_pix[7:0]}) * kw;
    assign prod_g   = $signed({1'b0, cell_pix[15:8]}) * kw;
    assign prod_b   = $signed({1'b0, cell_pix[23:16]}) * kw;

    // The divider starts once the last cell has been added to the sums.
    assign div_start = (state_reg == ST_GATHER) && (step_reg == 4'd11);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    // Sequencer, counters and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            image_width_reg <= IW_W'(640);
            kern_top_reg    <= KERN_W'(66049);
            kern_mid_reg    <= KERN_W'(132098);
            kern_bot_reg    <= KERN_W'(66049);
            norm_reg        <= NORM_W'(16);
            head_reg        <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            pend_reg        <= '0;
            last_reg        <= 1'b0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        image_width_reg <= cfg_wdata[IW_W-1:0];
                        col_reg         <= '0;
                        row_reg         <= '0;
                        pend_reg        <= '0;
                    end
                    REG_KERNEL_TOP:    kern_top_reg <= cfg_wdata[KERN_W-1:0];
                    REG_KERNEL_MIDDLE: kern_mid_reg <= cfg_wdata[KERN_W-1:0];
                    REG_KERNEL_BOTTOM: kern_bot_reg <= cfg_wdata[KERN_W-1:0];
                    REG_NORMALISER:    norm_reg     <= cfg_wdata[NORM_W-1:0];
                    default:           ;
                endcase
            end

            if (out_ch.ready && out_valid_reg && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !in_ch.mode)
                    begin
                        head_reg <= (head_reg == SLOT_W'(RING_SLOTS - 1)) ? '0
                                  : head_reg + SLOT_W'(1);
                        if (col_inc >= w)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 16'd1;
                        end
                        else
                        begin
                            col_reg <= col_inc;
                        end
                        pend_reg <= pend_inc;
                        last_reg <= 1'b0;
                        if (emit_pix)
                        begin
                            state_reg <= ST_SETUP;
                        end
                    end
                    else if (accept && pend_reg != '0)
                    begin
                        last_reg  <= (pend_reg == WID_W'(1));
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    pend_reg <= pend_reg - WID_W'(1);
                    if (pend_reg == WID_W'(1))
                    begin
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    step_reg  <= '0;
                    state_reg <= ST_GATHER;
                end
                ST_GATHER:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd11)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Window datapath: locate, gather and accumulate.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
        begin
            cc_reg       <= cc_s[WID_W-1:0];
            rr_zero_reg  <= (rr_s == 16'd0);
            oslot_reg    <= oslot_next;
            pend_use_reg <= pend_reg;
            sum_r_reg    <= '0;
            sum_g_reg    <= '0;
            sum_b_reg    <= '0;
        end
        if (state_reg == ST_GATHER)
        begin
            inside_reg <= inside_next;
            if (step_reg == 4'd1)
            begin
                center_reg <= ram_rdata;
            end
            else if (step_reg >= 4'd2 && step_reg <= 4'd10)
            begin
                sum_r_reg <= sum_r_reg + SUM_W'(prod_r);
                sum_g_reg <= sum_g_reg + SUM_W'(prod_g);
                sum_b_reg <= sum_b_reg + SUM_W'(prod_b);
            end
        end
        if (out_load)
        begin
            red_out_reg    <= quot_r;
            green_out_reg  <= quot_g;
            blue_out_reg   <= quot_b;
            frame_last_reg <= last_reg;
        end
    end

    c3rgb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RING_SLOTS)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (pix_in),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    c3rgb_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .sum_r      (sum_r_reg),
        .sum_g      (sum_g_reg),
        .sum_b      (sum_b_reg),
        .normaliser (norm_reg),
        .done       (div_done),
        .quot_r     (quot_r),
        .quot_g     (quot_g),
        .quot_b     (quot_b)
    );

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.red_out    = red_out_reg;
    assign out_ch.green_out  = green_out_reg;
    assign out_ch.blue_out   = blue_out_reg;
    assign out_ch.frame_last = frame_last_reg;

    // Pending count never exceeds one row plus one while idle.
    `C3_ASSERT_IMP(a_pend_bound, clk, rst_n, state_reg == ST_IDLE, pend_reg <= w_plus1)
    // The ring is written only when an item is taken in idle.
    `C3_ASSERT_IMP(a_write_idle, clk, rst_n, ram_we, state_reg == ST_IDLE)
    // Setup always hands over to the gather pass.
    `C3_ASSERT_NEXT(a_setup_gather, clk, rst_n, state_reg == ST_SETUP, state_reg == ST_GATHER)
    // The divider finishes only while the sequencer waits for it.
    `C3_ASSERT_IMP(a_div_done, clk, rst_n, div_done, state_reg == ST_DIV)
endmodule

[test/conv3x3_rgb_center_border_tb.sv]
// Self-checking testbench of the 3x3 RGB filter: class scoreboard with its own filter model.
`timescale 1ns / 1ps

module conv3x3_rgb_center_border_tb;
    import c3rgb_pkg::*;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } filtered_px_t;

    // Filter model and queue of filtered pixels still to arrive.
    class conv_scoreboard;
        logic [IW_W-1:0]   width_reg;
        logic [KERN_W-1:0] kern [3];
        logic [NORM_W-1:0] norm_reg;
        logic [PIX_W-1:0]  ring [RING_SLOTS];
        int unsigned       col, row, pend, head;
        filtered_px_t      awaited [$];
        int                errors;
        int                results;

        function new();
            width_reg = IW_W'(640);
            kern[0] = 24'h010201;
            kern[1] = 24'h020402;
            kern[2] = 24'h010201;
            norm_reg = NORM_W'(16);
            col = 0; row = 0; pend = 0; head = 0;
            errors = 0; results = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH:
                begin
                    width_reg = data[IW_W-1:0];
                    col = 0; row = 0; pend = 0;
                end
                REG_KERNEL_TOP:    kern[0] = data;
                REG_KERNEL_MIDDLE: kern[1] = data;
                REG_KERNEL_BOTTOM: kern[2] = data;
                REG_NORMALISER:    norm_reg = data[NORM_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] scale(int sum);
            int d, q;
            d = (norm_reg == 0) ? 1 : int'(norm_reg);
            q = sum / d;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
            return q[7:0];
        endfunction

        // Weighted window around the oldest pending pixel.
        function void filter_oldest(logic last);
            int w, cc, rr, off, k;
            int sr, sg, sb;
            int unsigned oslot;
            logic [PIX_W-1:0] center, nb_pix;
            logic in_img;
            filtered_px_t px;
            w = eff_width();
            oslot = (head + RING_SLOTS - pend) % RING_SLOTS;
            cc = int'(col) - int'(pend);
            rr = row;
            while (cc < 0)
            begin
                cc += w;
                rr = (rr - 1) & 16'hFFFF;
            end
            center = ring[oslot];
            sr = 0; sg = 0; sb = 0;
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    off = dr * w + dc;
                    in_img = (cc + dc >= 0) && (cc + dc < w);
                    if (dr < 0 && rr == 0) in_img = 0;
                    if (off > 0 && off >= int'(pend)) in_img = 0;
                    nb_pix = in_img ? ring[(int'(oslot) + RING_SLOTS + off) % RING_SLOTS]
                                    : center;
                    k = $signed(kern[dr + 1][8*(dc + 1) +: 8]);
                    sr += int'(nb_pix[7:0]) * k;
                    sg += int'(nb_pix[15:8]) * k;
                    sb += int'(nb_pix[23:16]) * k;
                end
            end
            px.red = scale(sr);
            px.green = scale(sg);
            px.blue = scale(sb);
            px.last = last;
            awaited = {awaited, px};
        endfunction

        // Notes one accepted request on the input channel.
        function void note_input(logic mode, logic [PIX_W-1:0] pix);
            int unsigned w;
            w = eff_width();
            if (mode == MODE_PIXEL)
            begin
                ring[head] = pix;
                head = (head + 1) % RING_SLOTS;
                col++;
                if (col >= w)
                begin
                    col = 0;
                    row = (row + 1) & 16'hFFFF;
                end
                pend++;
                if (pend > w + 1)
                begin
                    filter_oldest(1'b0);
                    pend--;
                end
            end
            else if (pend != 0)
            begin
                filter_oldest(pend == 1);
                pend--;
                if (pend == 0)
                begin
                    col = 0;
                    row = 0;
                end
            end
        endfunction

        // Compares one accepted output request with the oldest awaited pixel.
        function void check_result(filtered_px_t got);
            filtered_px_t want;
            results++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output r=%0d g=%0d b=%0d last=%0b",
                             got.red, got.green, got.blue, got.last);
                return;
            end
            want = awaited.pop_front();
            if (got.red != want.red || got.green != want.green ||
                got.blue != want.blue || got.last != want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp r=%0d g=%0d b=%0d l=%0b got r=%0d g=%0d b=%0d l=%0b",
                             want.red, want.green, want.blue, want.last,
                             got.red, got.green, got.blue, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic calm;
    int   items_sent;
    int   frames_run;

    c3rgb_in_if  in_ch();
    c3rgb_out_if out_ch();
    conv_scoreboard sb = new();

    conv3x3_rgb_center_border u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Output side: random stalls and checking of accepted requests.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.red_out, out_ch.green_out, out_ch.blue_out,
                             out_ch.frame_last});
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
    end

    // Sends one request, at times with a random gap before it.
    task automatic send_item(logic mode, logic [PIX_W-1:0] pix);
        if (!calm && $urandom_range(99) < 37)
        begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 37);
        end
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= mode;
        in_ch.red_in   <= pix[7:0];
        in_ch.green_in <= pix[15:8];
        in_ch.blue_in  <= pix[23:16];
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_input(mode, pix);
        items_sent++;
    endtask

    // Register write once the block has drained.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] rand_pix();
        case ($urandom_range(7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [KERN_W-1:0] rand_kernel();
        case ($urandom_range(5))
            0:       return 24'h7F7F7F;
            1:       return 24'h808080;
            2:       return 24'h000000;
            default: return KERN_W'($urandom);
        endcase
    endfunction

    // One frame of n pixels, then, if asked, a flush that may take stray pixels.
    task automatic run_frame(int n, bit flush, bit mixed, int extra);
        for (int i = 0; i < n; i++)
            send_item(MODE_PIXEL, rand_pix());
        if (flush)
        begin
            while (sb.pend != 0)
            begin
                if (mixed && $urandom_range(9) == 0)
                    send_item(MODE_PIXEL, rand_pix());
                else
                    send_item(MODE_FLUSH, PIX_W'($urandom));
            end
            for (int i = 0; i < extra; i++)
                send_item(MODE_FLUSH, PIX_W'($urandom));
        end
        frames_run++;
    endtask

    initial
    begin
        int w, calm_frame, n;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_PIXEL;
        in_ch.red_in = 8'd0;
        in_ch.green_in = 8'd0;
        in_ch.blue_in = 8'd0;
        cfg_we = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_wdata = '0;
        calm = 1'b0;
        items_sent = 0;
        frames_run = 0;
        @(posedge rst_n);
        @(posedge clk);

        // Directed: small frame with extreme pixels, pixel inside a flush, empty flush.
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4));
        write_reg(REG_KERNEL_TOP, 24'h010201);
        write_reg(REG_KERNEL_MIDDLE, 24'h020402);
        write_reg(REG_KERNEL_BOTTOM, 24'h010201);
        write_reg(REG_NORMALISER, CFG_DATA_W'(16));
        for (int i = 0; i < 10; i++)
            send_item(MODE_PIXEL, (i % 2) ? 24'hFFFFFF : 24'h000000);
        send_item(MODE_FLUSH, 24'h0);
        send_item(MODE_PIXEL, 24'hFF00FF);
        run_frame(0, 1'b1, 1'b0, 2);

        // Saturation high, saturation low, zero divisor, largest divisor, spare indexes.
        write_reg(REG_KERNEL_TOP, 24'h7F7F7F);
        write_reg(REG_KERNEL_MIDDLE, 24'h7F7F7F);
        write_reg(REG_KERNEL_BOTTOM, 24'h7F7F7F);
        write_reg(REG_NORMALISER, CFG_DATA_W'(0));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
        run_frame(3, 1'b1, 1'b0, 0);
        write_reg(REG_KERNEL_MIDDLE, 24'h808080);
        write_reg(REG_NORMALISER, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
        run_frame(5, 1'b1, 1'b0, 0);
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));

        // Random frames, some cut short by a width write.
        calm_frame = $urandom_range(5, 15);
        for (int f = 0; items_sent < 430; f++)
        begin
            calm = (f == calm_frame);
            case ($urandom_range(9))
                0:       w = 1;
                1:       w = 0;
                2:       w = $urandom_range(13, 40);
                default: w = $urandom_range(2, 8);
            endcase
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
            if ($urandom_range(2) == 0) write_reg(REG_KERNEL_TOP, rand_kernel());
            if ($urandom_range(2) == 0) write_reg(REG_KERNEL_MIDDLE, rand_kernel());
            if ($urandom_range(2) == 0) write_reg(REG_KERNEL_BOTTOM, rand_kernel());
            if ($urandom_range(2) == 0)
                write_reg(REG_NORMALISER,
                          CFG_DATA_W'(($urandom_range(9) == 0) ? $urandom
                                                               : $urandom_range(0, 40)));
            if ($urandom_range(7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                          CFG_DATA_W'($urandom));
            if (w == 0) w = 1;
            n = w * $urandom_range(1, 5) + $urandom_range(0, w - 1);
            if (n > 450 - items_sent) n = 450 - items_sent;
            run_frame(n, $urandom_range(9) != 0, $urandom_range(3) == 0,
                      $urandom_range(0, 2));
        end
        calm = 1'b0;

        // One short frame with the width field at its top value.
        write_reg(REG_KERNEL_TOP, CFG_DATA_W'($urandom));
        write_reg(REG_KERNEL_MIDDLE, CFG_DATA_W'($urandom));
        write_reg(REG_KERNEL_BOTTOM, CFG_DATA_W'($urandom));
        write_reg(REG_NORMALISER, CFG_DATA_W'($urandom_range(1, 300)));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(12'hFFF));
        run_frame(60, 1'b1, 1'b0, 1);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests in %0d frames; %0d filtered pixels checked.",
                 items_sent, frames_run, sb.results);
        $display("Widths from one to the top of the width field, edge kernels and divisors were covered.");
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
